// ----- sv/tpw_pkg.sv -----
// Package for the two-level page walker: sizes, entry bit positions, codes and types.
// Used by two_level_page_walker; depends on nothing else.

package tpw_pkg;

  // Table memory geometry. TableWords must be a power of two so that word
  // indices wrap by truncation.
  localparam int unsigned TableWords      = 16384;
  localparam int unsigned TableAw         = $clog2(TableWords);
  localparam int unsigned EntriesPerTable = 1024;
  localparam int unsigned IdxW            = $clog2(EntriesPerTable);

  // Entry bit positions.
  localparam int unsigned PresentPos = 0;
  localparam int unsigned UserPos    = 2;
  localparam int unsigned LargePos   = 7;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_DIR_PAGE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RAM_LIMIT = 1'b1;

  localparam int unsigned DirPageW  = 4;
  localparam int unsigned RamLimitW = 17;
  localparam int unsigned CfgDataW  = 17;

  // Request codes.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_XLATE = 2'd2
  } func_e;

  // Walker states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIR,
    ST_TBL,
    ST_WAIT
  } state_e;

  // One result beat.
  typedef struct packed {
    logic [31:0] read_data;
    logic        present;
    logic [31:0] phys_addr;
    logic [31:0] entry;
    logic        user_ok;
  } res_t;

  // Word index of a directory entry, wrapped to the memory size.
  function automatic logic [TableAw-1:0] dir_index(logic [DirPageW-1:0] page,
                                                   logic [IdxW-1:0] pd);
    logic [31:0] full;
    full = {18'b0, page, pd};
    return full[TableAw-1:0];
  endfunction

  // Word index of a table entry: the frame bits of the directory entry give the
  // table's page, the table index picks the word within it.
  function automatic logic [TableAw-1:0] tbl_index(logic [19:0] frame,
                                                   logic [IdxW-1:0] pt);
    logic [31:0] full;
    full = {2'b0, frame, pt};
    return full[TableAw-1:0];
  endfunction

  // Word index from the request's word address, wrapped to the memory size.
  function automatic logic [TableAw-1:0] word_index(logic [13:0] waddr);
    logic [31:0] full;
    full = {18'b0, waddr};
    return full[TableAw-1:0];
  endfunction

endpackage

// ----- sv/tpw_ram.sv -----
// Single-port synchronous RAM with registered read data.
// Generic storage for the page walker; no package dependency.

module tpw_ram #(
  parameter int unsigned AddrW = 14,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // One access per cycle: write or read at the same address.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/two_level_page_walker.sv -----
// Top level of the two-level page walker: request decode, walk sequencer, result buffer.
// Depends on tpw_pkg and tpw_ram.
//
//   Channel   Direction  Handshake                  Beat contents
//   in        input      in_valid_i / in_stall_o    func, word_addr, write_data, virt_addr
//   out       output     out_valid_o / out_stall_i  read_data, present, phys_addr, entry, user_ok
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// A write or an unused code finishes in ST_IDLE, a read in ST_READ, a translation in ST_DIR
// when it ends at the directory (not present, large page, bad pointer) and in ST_TBL for a
// full walk. Each walk step reads the single-port table memory, whose read data is registered.
// Reset clears the walker state, the output valid flag and both configuration registers, not the
// table memory or result payloads. A stalled result sits in the output register, a second one in
// a skid register, and new requests are taken while the output register is occupied.

module two_level_page_walker
  import tpw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [13:0]          word_addr_i,
  input  logic [31:0]          write_data_i,
  input  logic [31:0]          virt_addr_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          read_data_o,
  output logic                 present_o,
  output logic [31:0]          phys_addr_o,
  output logic [31:0]          entry_o,
  output logic                 user_ok_o,
  // Configuration port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i
);

  state_e               state_q, state_d;
  logic [DirPageW-1:0]  dir_page_q;
  logic [RamLimitW-1:0] ram_limit_q;
  logic [21:0]          va_q, va_d;
  logic                 pde_user_q, pde_user_d;
  res_t                 out_q, pend_q;
  logic                 out_valid_q;

  logic                 ram_en, ram_we;
  logic [TableAw-1:0]   ram_addr;
  logic [31:0]          ram_rdata;

  logic                 accept, out_free, fin, load_out;
  res_t                 res, res_sel;
  logic [31:0]          pt_base;
  logic                 bad_ptr;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_page_q  <= '0;
      ram_limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIR_PAGE:  dir_page_q  <= cfg_wdata_i[DirPageW-1:0];
        CFG_RAM_LIMIT: ram_limit_q <= cfg_wdata_i[RamLimitW-1:0];
        default: ;
      endcase
    end
  end

  // Table memory.
  tpw_ram #(
    .AddrW(TableAw),
    .DataW(32)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(write_data_i),
    .rdata_o(ram_rdata)
  );

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Table pointer check on the directory entry now on the read port.
  assign pt_base = {ram_rdata[31:12], 12'b0};
  assign bad_ptr = (ram_rdata[31:12] == 20'b0) || (ram_limit_q == '0) ||
                   (pt_base >= {15'b0, ram_limit_q});

  // Walk sequencer: memory port control, result forming and next state.
  always_comb begin
    state_d    = state_q;
    va_d       = va_q;
    pde_user_d = pde_user_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = word_index(word_addr_i);
    fin        = 1'b0;
    res        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          va_d = virt_addr_i[21:0];
          case (func_e'(func_i))
            FUNC_WRITE: begin
              ram_en = 1'b1;
              ram_we = 1'b1;
              fin    = 1'b1;
            end
            FUNC_READ: begin
              ram_en  = 1'b1;
              state_d = ST_READ;
            end
            FUNC_XLATE: begin
              ram_en   = 1'b1;
              ram_addr = dir_index(dir_page_q, virt_addr_i[31:22]);
              state_d  = ST_DIR;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        fin           = 1'b1;
        res.read_data = ram_rdata;
      end

      ST_DIR: begin
        if (!ram_rdata[PresentPos]) begin
          fin = 1'b1;
        end else if (ram_rdata[LargePos]) begin
          // Large page: base and offset do not overlap, so no add is needed.
          fin           = 1'b1;
          res.present   = 1'b1;
          res.phys_addr = {ram_rdata[31:22], va_q};
          res.entry     = {ram_rdata[31:22], va_q[21:12], ram_rdata[11:0]};
          res.user_ok   = ram_rdata[UserPos];
        end else if (bad_ptr) begin
          fin = 1'b1;
        end else begin
          ram_en     = 1'b1;
          ram_addr   = tbl_index(ram_rdata[31:12], va_q[21:12]);
          pde_user_d = ram_rdata[UserPos];
          state_d    = ST_TBL;
        end
      end

      ST_TBL: begin
        fin = 1'b1;
        if (ram_rdata[PresentPos]) begin
          res.present   = 1'b1;
          res.phys_addr = {ram_rdata[31:12], va_q[11:0]};
          res.entry     = ram_rdata;
          res.user_ok   = pde_user_q && ram_rdata[UserPos];
        end
      end

      ST_WAIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? ST_IDLE : ST_WAIT;
    end
  end

  // The output register takes a fresh result, or the skid copy once it drains.
  assign load_out = out_free && (fin || (state_q == ST_WAIT));
  assign res_sel  = (state_q == ST_WAIT) ? pend_q : res;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && out_stall_i);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    va_q       <= va_d;
    pde_user_q <= pde_user_d;
    if (load_out) begin
      out_q <= res_sel;
    end
    if (fin && !out_free) begin
      pend_q <= res;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = out_q.read_data;
  assign present_o   = out_q.present;
  assign phys_addr_o = out_q.phys_addr;
  assign entry_o     = out_q.entry;
  assign user_ok_o   = out_q.user_ok;

endmodule
